FILE: design/gpta_pkg.sv
// Shared types and constants for the display-list primitive triangle assembler.
// Holds the channel request structs, the queued triangle job and the parser codes.
// No dependencies.
package gpta_pkg;

	// Largest vertex count that a run header may carry.
	localparam int MAX_RUN = 4096;
	// Largest number of 16-bit indices in one vertex tuple.
	localparam int MAX_TUPLE = 4;
	// Default number of triangle jobs held between parser and emitter.
	localparam int JOB_DEPTH = 4;

	// Command byte decoding.
	localparam logic [7:0] CMD_MASK  = 8'hf8;
	localparam logic [7:0] CMD_QUADS = 8'h80;
	localparam logic [7:0] CMD_TRIS  = 8'h90;
	localparam logic [7:0] CMD_STRIP = 8'h98;
	localparam logic [7:0] CMD_FAN   = 8'ha0;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_RUN,
		PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		KIND_QUADS,
		KIND_TRIS,
		KIND_STRIP,
		KIND_FAN
	} kind_t;

	typedef enum logic {
		CFG_TUPLE_COUNT = 1'b0,
		CFG_LIST_LENGTH = 1'b1
	} cfg_reg_t;

	// One display-list byte request.
	typedef struct packed {
		logic [7:0] list_byte;
		logic       first_byte;
	} list_item_t;

	// One triangle corner request.
	typedef struct packed {
		logic [15:0] index_a;
		logic [15:0] index_b;
		logic [15:0] index_c;
		logic [15:0] index_d;
		logic [1:0]  corner;
		logic        last_of_run;
	} corner_item_t;

	// Work caused by one byte: triangle (t0,t1,t2) and, when two_tri is set,
	// a second triangle (t0,t2,t3).
	typedef struct packed {
		logic [63:0] t0;
		logic [63:0] t1;
		logic [63:0] t2;
		logic [63:0] t3;
		logic        two_tri;
	} tri_job_t;

endpackage

FILE: design/gpta_byte_parse.sv
// Front end of the triangle assembler: configuration registers, byte parser,
// vertex tuple assembly and triangle job generation. Depends on gpta_pkg.
module gpta_byte_parse
	import gpta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [0:0] cfg_index,
	input  logic [23:0] cfg_data,
	input  logic       accept,
	input  list_item_t item,
	output logic       job_push,
	output tri_job_t   job
);

	localparam logic [15:0] MAX_RUN_W   = 16'(MAX_RUN);
	localparam logic [2:0]  MAX_TUPLE_W = 3'(MAX_TUPLE);

	logic [2:0]  tuple_count_q;
	logic [23:0] list_length_q;
	phase_t      phase_q, phase_d, phase_cur;
	logic [23:0] pos_q, pos_d, pos_cur;
	kind_t       kind_q, kind_d;
	logic [1:0]  hstep_q, hstep_d, hstep_cur;
	logic [15:0] run_q, run_d;
	logic [12:0] vnum_q, vnum_d;
	logic [1:0]  vmod3_q, vmod3_d;
	logic [2:0]  tbyte_q, tbyte_d;
	logic [63:0] build_q, build_d;
	logic [63:0] pivot_q, pivot_d;
	logic [63:0] r1_q, r2_q, r1_d, r2_d;

	logic [2:0]  eff;
	logic [7:0]  b;
	logic        hdr_short, tail_short;
	logic [23:0] left;
	logic [15:0] run_full;
	logic [18:0] prod;
	logic [19:0] need;
	logic [63:0] base_build, new_build;
	logic [3:0]  tb_next;
	logic [13:0] i_next;
	logic [2:0]  lane;

	// Effective tuple count, clamped into the supported range.
	always_comb begin
		eff = tuple_count_q;
		if (eff == 3'd0) eff = 3'd1;
		if (eff > MAX_TUPLE_W) eff = MAX_TUPLE_W;
	end

	// Header position and length checks, and run-phase byte assembly.
	always_comb begin
		b          = item.list_byte;
		pos_cur    = item.first_byte ? 24'd0 : pos_q;
		phase_cur  = item.first_byte ? PH_HEADER : phase_q;
		hstep_cur  = item.first_byte ? 2'd0 : hstep_q;
		hdr_short  = ({1'b0, pos_cur} + 25'd3) > {1'b0, list_length_q};
		tail_short = ({1'b0, pos_cur} + 25'd1) > {1'b0, list_length_q};
		left       = list_length_q - pos_cur - 24'd1;
		run_full   = {run_q[15:8], b};
		prod       = 19'(run_full) * 19'(eff);
		need       = {prod, 1'b0};
		lane       = tbyte_q ^ 3'd1;
		base_build = (tbyte_q == 3'd0) ? 64'd0 : build_q;
		new_build  = base_build | (64'(b) << {lane, 3'b000});
		tb_next    = {1'b0, tbyte_q} + 4'd1;
		i_next     = {1'b0, vnum_q} + 14'd1;
	end

	// Next parser state and the triangle job caused by this byte.
	always_comb begin
		phase_d  = phase_cur;
		hstep_d  = hstep_cur;
		pos_d    = (pos_cur != 24'hffffff) ? pos_cur + 24'd1 : pos_cur;
		kind_d   = kind_q;
		run_d    = run_q;
		vnum_d   = vnum_q;
		vmod3_d  = vmod3_q;
		tbyte_d  = tbyte_q;
		build_d  = build_q;
		pivot_d  = pivot_q;
		r1_d     = r1_q;
		r2_d     = r2_q;
		job_push = 1'b0;
		job      = '0;
		case (phase_cur)
			PH_HEADER: begin
				if (hstep_cur == 2'd0) begin
					if (hdr_short || b == 8'd0) begin
						phase_d = PH_STOP;
					end else begin
						case (b & CMD_MASK)
							CMD_QUADS: begin kind_d = KIND_QUADS; hstep_d = 2'd1; end
							CMD_TRIS:  begin kind_d = KIND_TRIS;  hstep_d = 2'd1; end
							CMD_STRIP: begin kind_d = KIND_STRIP; hstep_d = 2'd1; end
							CMD_FAN:   begin kind_d = KIND_FAN;   hstep_d = 2'd1; end
							default:   phase_d = PH_STOP;
						endcase
					end
				end else if (hstep_cur == 2'd1) begin
					run_d   = {b, 8'd0};
					hstep_d = 2'd2;
				end else begin
					run_d   = run_full;
					hstep_d = 2'd0;
					if (tail_short || run_full > MAX_RUN_W || left < {4'd0, need}) begin
						phase_d = PH_STOP;
					end else if (run_full != 16'd0) begin
						phase_d = PH_RUN;
						vnum_d  = 13'd0;
						vmod3_d = 2'd0;
						tbyte_d = 3'd0;
					end
				end
			end
			PH_RUN: begin
				build_d = new_build;
				if (tb_next >= {eff, 1'b0}) begin
					// The vertex tuple is complete: slide the window of the two most
					// recent tuples.
					tbyte_d = 3'd0;
					r1_d    = r2_q;
					r2_d    = new_build;
					case (kind_q)
						KIND_QUADS: begin
							if (vnum_q[1:0] == 2'd0) pivot_d = new_build;
							if (vnum_q[1:0] == 2'd3) begin
								job_push = 1'b1;
								job      = '{t0: pivot_q, t1: r1_q, t2: r2_q,
									t3: new_build, two_tri: 1'b1};
							end
						end
						KIND_TRIS: begin
							if (vmod3_q == 2'd2) begin
								job_push = 1'b1;
								job      = '{t0: r1_q, t1: r2_q, t2: new_build,
									t3: 64'd0, two_tri: 1'b0};
							end
						end
						KIND_STRIP: begin
							// Degenerate windows, with a repeated position index, are dropped.
							if (vnum_q >= 13'd2 && r1_q[15:0] != r2_q[15:0] &&
									r2_q[15:0] != new_build[15:0] &&
									r1_q[15:0] != new_build[15:0]) begin
								job_push = 1'b1;
								if (vnum_q[0]) begin
									job = '{t0: r2_q, t1: r1_q, t2: new_build,
										t3: 64'd0, two_tri: 1'b0};
								end else begin
									job = '{t0: r1_q, t1: r2_q, t2: new_build,
										t3: 64'd0, two_tri: 1'b0};
								end
							end
						end
						KIND_FAN: begin
							if (vnum_q == 13'd0) pivot_d = new_build;
							if (vnum_q >= 13'd2) begin
								job_push = 1'b1;
								job      = '{t0: pivot_q, t1: r2_q, t2: new_build,
									t3: 64'd0, two_tri: 1'b0};
							end
						end
						default: job_push = 1'b0;
					endcase
					vnum_d = i_next[12:0];
					// Vertex number modulo three, restarted when the counter wraps.
					if (vnum_q == 13'h1fff || vmod3_q == 2'd2) begin
						vmod3_d = 2'd0;
					end else begin
						vmod3_d = vmod3_q + 2'd1;
					end
					if ({2'd0, i_next} >= run_q) phase_d = PH_HEADER;
				end else begin
					tbyte_d = tb_next[2:0];
				end
			end
			default: phase_d = PH_STOP;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuple_count_q <= 3'd1;
			list_length_q <= 24'd0;
		end else if (cfg_valid) begin
			if (cfg_reg_t'(cfg_index) == CFG_TUPLE_COUNT) begin
				tuple_count_q <= cfg_data[2:0];
			end else begin
				list_length_q <= cfg_data;
			end
		end
	end

	// Parser state, advanced once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 24'd0;
			kind_q  <= KIND_QUADS;
			hstep_q <= 2'd0;
			run_q   <= 16'd0;
			vnum_q  <= 13'd0;
			vmod3_q <= 2'd0;
			tbyte_q <= 3'd0;
			build_q <= 64'd0;
			pivot_q <= 64'd0;
			r1_q    <= 64'd0;
			r2_q    <= 64'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			kind_q  <= kind_d;
			hstep_q <= hstep_d;
			run_q   <= run_d;
			vnum_q  <= vnum_d;
			vmod3_q <= vmod3_d;
			tbyte_q <= tbyte_d;
			build_q <= build_d;
			pivot_q <= pivot_d;
			r1_q    <= r1_d;
			r2_q    <= r2_d;
		end
	end

endmodule

FILE: design/gpta_job_queue.sv
// Small first-in first-out queue of triangle jobs between parser and emitter.
// Depends on gpta_pkg for the job type.
module gpta_job_queue
	import gpta_pkg::*;
#(
	parameter int DEPTH = JOB_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tri_job_t wr_job,
	input  logic     pop,
	output tri_job_t rd_job,
	output logic     empty,
	output logic     full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	tri_job_t          slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign rd_job = slot_q[rd_ptr_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_job;
	end

endmodule

FILE: design/gpta_corner_emit.sv
// Back end of the triangle assembler: walks the head job corner by corner into
// the output register. Depends on gpta_pkg.
module gpta_corner_emit
	import gpta_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  tri_job_t     job,
	input  logic         have_job,
	output logic         pop,
	output logic         tri_valid,
	input  logic         tri_stall,
	output corner_item_t tri_item
);

	logic         valid_q;
	corner_item_t item_q;
	logic [1:0]   step_q;
	logic         tri_sel_q;
	logic         load;
	logic         last_corner;
	logic [63:0]  tup;

	assign tri_valid = valid_q;
	assign tri_item  = item_q;

	// The output register may be refilled when empty or when its request is taken.
	assign load        = !valid_q || !tri_stall;
	assign last_corner = (step_q == 2'd2) && (tri_sel_q == job.two_tri);
	assign pop         = load && have_job && last_corner;

	// Tuple of the current corner: first triangle (t0,t1,t2), second (t0,t2,t3).
	always_comb begin
		case (step_q)
			2'd0:    tup = job.t0;
			2'd1:    tup = tri_sel_q ? job.t2 : job.t1;
			default: tup = tri_sel_q ? job.t3 : job.t2;
		endcase
	end

	// Output valid and corner sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			step_q    <= 2'd0;
			tri_sel_q <= 1'b0;
		end else if (load) begin
			valid_q <= have_job;
			if (have_job) begin
				if (step_q == 2'd2) begin
					step_q    <= 2'd0;
					tri_sel_q <= last_corner ? 1'b0 : 1'b1;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load && have_job) begin
			item_q.index_a     <= tup[15:0];
			item_q.index_b     <= tup[31:16];
			item_q.index_c     <= tup[47:32];
			item_q.index_d     <= tup[63:48];
			item_q.corner      <= step_q;
			item_q.last_of_run <= last_corner;
		end
	end

endmodule

FILE: design/gx_primitive_triangle_assembler.sv
// Display-list primitive triangle assembler, top level.
// Depends on gpta_pkg, gpta_byte_parse, gpta_job_queue and gpta_corner_emit.
//
// Usage: display-list bytes enter on the list channel (list_valid, list_stall,
// list_item), one byte per cycle, with first_byte set on byte 0 of each list.
// Triangle corners leave on the tri channel (tri_valid, tri_stall, tri_item),
// three corners per triangle, last_of_run set on the final corner caused by a
// byte. The cfg channel writes tuple_count (index 0) and list_length (index 1);
// cfg_ready is always high and writes take effect at the next edge.
// Throughput: one byte per cycle at the input and, while tri_stall is low, one
// corner per cycle at the output. The parser accepts a byte every cycle while
// the job queue has room; a quad can yield six corners from one byte, so a
// steady run of short vertex tuples is limited to one corner per cycle by the
// emitter. An accepted byte writes its job into the queue when it is accepted,
// and the emitter loads the first corner from the queue head into the output register.
// When the receiver stalls, the output register holds its corner, the queue of
// QUEUE_DEPTH jobs fills, and list_stall rises once the queue is full.
// Reset clears the parser to wait for a command byte, restores tuple_count to
// one and list_length to zero, and empties the queue and the output register.
module gx_primitive_triangle_assembler
	import gpta_pkg::*;
#(
	parameter int QUEUE_DEPTH = JOB_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         list_valid,
	output logic         list_stall,
	input  list_item_t   list_item,
	output logic         tri_valid,
	input  logic         tri_stall,
	output corner_item_t tri_item,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	logic     accept;
	logic     job_push;
	tri_job_t new_job;
	tri_job_t head_job;
	logic     queue_empty;
	logic     queue_full;
	logic     pop;

	assign cfg_ready  = 1'b1;
	assign list_stall = queue_full;
	assign accept     = list_valid && !list_stall;

	// Front end: parse bytes into triangle jobs.
	gpta_byte_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.item     (list_item),
		.job_push (job_push),
		.job      (new_job)
	);

	// Decoupling queue between parser and emitter.
	gpta_job_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept && job_push),
		.wr_job(new_job),
		.pop   (pop),
		.rd_job(head_job),
		.empty (queue_empty),
		.full  (queue_full)
	);

	// Back end: emit corners one per cycle while tri_stall is low.
	gpta_corner_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (head_job),
		.have_job (!queue_empty),
		.pop      (pop),
		.tri_valid(tri_valid),
		.tri_stall(tri_stall),
		.tri_item (tri_item)
	);

endmodule

FILE: bench/gpta_corner_checker.sv
`timescale 1ns / 1ps
// Checker for the primitive triangle assembler: predicts the corners that each accepted list byte
// causes and compares every corner request that leaves the block with the oldest prediction.
// Depends on gpta_pkg.
module gpta_corner_checker
	import gpta_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         list_valid,
	input  logic         list_stall,
	input  list_item_t   list_item,
	input  logic         tri_valid,
	input  logic         tri_stall,
	input  corner_item_t tri_item,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	output int           fail_count,
	output int           corners_owed,
	output int           bytes_taken,
	output int           corners_checked
);

	// Register copies and parser state of the predictor.
	logic [2:0]   tuple_cnt;
	logic [23:0]  list_len;
	phase_t       phase;
	logic [23:0]  pos_cnt;
	kind_t        kind;
	logic [1:0]   hdr_step;
	logic [15:0]  run_cnt;
	logic [12:0]  vert_num;
	logic [2:0]   tup_byte;
	logic [63:0]  tup_build;
	logic [63:0]  pivot;
	logic [63:0]  recent [3];
	corner_item_t corners_due [$];

	// Indices per vertex; out-of-range register values are clamped.
	function automatic int tuple_span();
		if (tuple_cnt == 3'd0)
			return 1;
		if (tuple_cnt > MAX_TUPLE)
			return MAX_TUPLE;
		return tuple_cnt;
	endfunction

	task automatic reset_model();
		tuple_cnt = 3'd1;
		list_len = '0;
		phase = PH_HEADER;
		pos_cnt = '0;
		kind = KIND_QUADS;
		hdr_step = '0;
		run_cnt = '0;
		vert_num = '0;
		tup_byte = '0;
		tup_build = '0;
		pivot = '0;
		foreach (recent[i])
			recent[i] = '0;
		corners_due.delete();
	endtask

	task automatic push_corner(logic [63:0] tup, logic [1:0] slot);
		corner_item_t c;
		c.index_a = tup[15:0];
		c.index_b = tup[31:16];
		c.index_c = tup[47:32];
		c.index_d = tup[63:48];
		c.corner = slot;
		c.last_of_run = 1'b0;
		corners_due.push_back(c);
	endtask

	task automatic push_triangle(logic [63:0] t0, logic [63:0] t1, logic [63:0] t2);
		push_corner(t0, 2'd0);
		push_corner(t1, 2'd1);
		push_corner(t2, 2'd2);
	endtask

	// A vertex tuple is complete: shift it into the window and emit whatever it closes.
	task automatic close_vertex();
		int i;
		i = vert_num;
		recent[0] = recent[1];
		recent[1] = recent[2];
		recent[2] = tup_build;
		case (kind)
			KIND_QUADS: begin
				if (i % 4 == 0)
					pivot = tup_build;
				if (i % 4 == 3) begin
					push_triangle(pivot, recent[0], recent[1]);
					push_triangle(pivot, recent[1], recent[2]);
				end
			end
			KIND_TRIS: begin
				if (i % 3 == 2)
					push_triangle(recent[0], recent[1], recent[2]);
			end
			KIND_STRIP: begin
				// Windows with a repeated position index are degenerate and dropped; odd
				// windows swap their first two corners to keep the winding.
				if (i >= 2 && recent[0][15:0] != recent[1][15:0]
						&& recent[1][15:0] != recent[2][15:0]
						&& recent[0][15:0] != recent[2][15:0]) begin
					if (i % 2 == 1)
						push_triangle(recent[1], recent[0], recent[2]);
					else
						push_triangle(recent[0], recent[1], recent[2]);
				end
			end
			default: begin
				if (i == 0)
					pivot = tup_build;
				if (i >= 2)
					push_triangle(pivot, recent[1], recent[2]);
			end
		endcase
		vert_num = 13'(i + 1);
		if (i + 1 >= run_cnt)
			phase = PH_HEADER;
	endtask

	// Advances the parser by one list byte and queues the corners that it causes.
	task automatic parse_byte(list_item_t item);
		int         pos;
		int         owed_before;
		int         tb;
		longint     need;
		longint     left;
		logic [7:0] b;
		b = item.list_byte;
		owed_before = corners_due.size();
		if (item.first_byte) begin
			phase = PH_HEADER;
			hdr_step = '0;
			pos_cnt = '0;
		end
		pos = pos_cnt;
		if (pos_cnt != '1)
			pos_cnt = pos_cnt + 1'b1;
		case (phase)
			PH_HEADER: begin
				if (hdr_step == 2'd0) begin
					// Fewer than three bytes left, or a zero byte, ends the list.
					if (int'(list_len) - pos < 3 || b == 8'h00) begin
						phase = PH_STOP;
					end else begin
						case (b & CMD_MASK)
							CMD_QUADS: begin
								kind = KIND_QUADS;
								hdr_step = 2'd1;
							end
							CMD_TRIS: begin
								kind = KIND_TRIS;
								hdr_step = 2'd1;
							end
							CMD_STRIP: begin
								kind = KIND_STRIP;
								hdr_step = 2'd1;
							end
							CMD_FAN: begin
								kind = KIND_FAN;
								hdr_step = 2'd1;
							end
							default: phase = PH_STOP;
						endcase
					end
				end else if (hdr_step == 2'd1) begin
					run_cnt = {b, 8'h00};
					hdr_step = 2'd2;
				end else begin
					// Count complete: the whole run has to fit in what is left of the list.
					run_cnt[7:0] = b;
					hdr_step = 2'd0;
					need = longint'(run_cnt) * 2 * tuple_span();
					left = longint'(list_len) - pos - 1;
					if (left < 0 || run_cnt > MAX_RUN || left < need) begin
						phase = PH_STOP;
					end else if (run_cnt != 16'd0) begin
						phase = PH_RUN;
						vert_num = '0;
						tup_byte = '0;
					end
				end
			end
			PH_RUN: begin
				// Indices arrive high byte first.
				tb = tup_byte;
				if (tb == 0)
					tup_build = '0;
				tup_build = tup_build | (64'(b) << (16 * (tb / 2) + ((tb % 2 == 1) ? 0 : 8)));
				tb++;
				if (tb >= 2 * tuple_span()) begin
					tup_byte = '0;
					close_vertex();
				end else begin
					tup_byte = 3'(tb);
				end
			end
			default: ;
		endcase
		if (corners_due.size() > owed_before)
			corners_due[corners_due.size() - 1].last_of_run = 1'b1;
	endtask

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_corner(corner_item_t got);
		corner_item_t want;
		if (corners_due.size() == 0) begin
			$error("corner request with none expected: index_a 0x%0h, corner %0d",
				got.index_a, got.corner);
			fail_count++;
		end else begin
			want = corners_due.pop_front();
			compare_field("index_a", want.index_a, got.index_a);
			compare_field("index_b", want.index_b, got.index_b);
			compare_field("index_c", want.index_c, got.index_c);
			compare_field("index_d", want.index_d, got.index_d);
			compare_field("corner", 16'(want.corner), 16'(got.corner));
			compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
		end
	endtask

	// Sample all three channels at the rising edge; predictions are queued before checking.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TUPLE_COUNT)
					tuple_cnt = cfg_data[2:0];
				else
					list_len = cfg_data;
			end
			if (list_valid && !list_stall) begin
				parse_byte(list_item);
				bytes_taken++;
			end
			if (tri_valid && !tri_stall) begin
				check_corner(tri_item);
				corners_checked++;
			end
		end
		corners_owed = corners_due.size();
	end

endmodule

FILE: bench/gx_primitive_triangle_assembler_tb.sv
`timescale 1ns / 1ps
// Top of the primitive triangle assembler testbench: clock, reset, list and register stimulus,
// the corner receiver and the verdict. Depends on gpta_pkg and gpta_corner_checker.
module gx_primitive_triangle_assembler_tb;
	import gpta_pkg::*;

	localparam int          ITEM_TARGET    = 330;
	localparam int          MAX_GAP        = 4;
	localparam int          HOLD_CYCLES    = 200;
	localparam int          SETTLE_CYCLES  = 8;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          FAN_LONG       = 24;
	localparam logic [23:0] LEN_MAX        = 24'hffffff;
	localparam logic [7:0]  CMD_END        = 8'h00;
	localparam logic [7:0]  CMD_UNKNOWN    = 8'hc0;
	localparam logic [2:0]  TUPLE_SWEEP [8] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};

	logic         clk;
	logic         arst_n;
	logic         list_valid;
	logic         list_stall;
	list_item_t   list_item;
	logic         tri_valid;
	logic         tri_stall;
	corner_item_t tri_item;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_index;
	logic [23:0]  cfg_data;

	int           fail_count;
	int           corners_owed;
	int           bytes_taken;
	int           corners_checked;

	logic [7:0]   list_bytes [$];
	int           items_sent;
	int           settings_run;
	logic         hold_req;
	bit           send_steady;

	gx_primitive_triangle_assembler u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.list_valid (list_valid),
		.list_stall (list_stall),
		.list_item  (list_item),
		.tri_valid  (tri_valid),
		.tri_stall  (tri_stall),
		.tri_item   (tri_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	gpta_corner_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.list_valid      (list_valid),
		.list_stall      (list_stall),
		.list_item       (list_item),
		.tri_valid       (tri_valid),
		.tri_stall       (tri_stall),
		.tri_item        (tri_item),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.corners_owed    (corners_owed),
		.bytes_taken     (bytes_taken),
		.corners_checked (corners_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int tuple_span(logic [2:0] tc);
		if (tc == 3'd0)
			return 1;
		return (tc > MAX_TUPLE) ? MAX_TUPLE : tc;
	endfunction

	// Offers one byte request after a random gap and returns at the falling edge after acceptance.
	task automatic send_byte(logic [7:0] value, logic first_flag);
		int gap;
		if (items_sent % 16 == 0)
			send_steady = ($urandom_range(0, 2) == 0);
		gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			list_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		list_item <= '{list_byte: value, first_byte: first_flag};
		list_valid <= 1'b1;
		@(posedge clk);
		while (list_stall)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_list();
		foreach (list_bytes[i])
			send_byte(list_bytes[i], i == 0);
	endtask

	// Waits until every predicted corner has left, then lets the block drain.
	task automatic settle();
		list_valid <= 1'b0;
		while (corners_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [23:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_registers(logic [2:0] tc, logic [23:0] len);
		cfg_write(CFG_TUPLE_COUNT, 24'(tc));
		cfg_write(CFG_LIST_LENGTH, len);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// Builds a list of well-formed commands with random indices, then an optional terminator
	// (zero byte, unknown command or oversized count) and a little trailing noise.
	task automatic build_list(int span);
		int          cmds;
		int          count;
		logic [7:0]  op;
		logic [15:0] idx;
		list_bytes.delete();
		cmds = $urandom_range(1, 3);
		repeat (cmds) begin
			case ($urandom_range(0, 3))
				0: begin
					op = CMD_QUADS;
					count = 4 * $urandom_range(0, 2);
				end
				1: begin
					op = CMD_TRIS;
					count = 3 * $urandom_range(0, 3);
				end
				2: begin
					op = CMD_STRIP;
					count = $urandom_range(0, 8);
				end
				default: begin
					op = CMD_FAN;
					count = $urandom_range(0, 8);
				end
			endcase
			// Now and then leave a primitive incomplete.
			if ($urandom_range(0, 5) == 0)
				count = $urandom_range(0, 9);
			list_bytes.push_back(op | 8'($urandom_range(0, 7)));
			list_bytes.push_back(8'(count >> 8));
			list_bytes.push_back(8'(count));
			repeat (count * span) begin
				// Small indices make degenerate strip windows likely.
				idx = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
				list_bytes.push_back(idx[15:8]);
				list_bytes.push_back(idx[7:0]);
			end
		end
		case ($urandom_range(0, 3))
			0: list_bytes.push_back(CMD_END);
			1: list_bytes.push_back(CMD_UNKNOWN | 8'($urandom_range(0, 7)));
			2: begin
				count = $urandom_range(MAX_RUN + 1, 65535);
				list_bytes.push_back(CMD_STRIP);
				list_bytes.push_back(8'(count >> 8));
				list_bytes.push_back(8'(count));
			end
			default: ;
		endcase
		repeat ($urandom_range(0, 2))
			list_bytes.push_back(8'($urandom));
	endtask

	// Builds one long fan, which yields a triangle for nearly every vertex.
	task automatic build_fan(int count, int span);
		logic [15:0] idx;
		list_bytes.delete();
		list_bytes.push_back(CMD_FAN);
		list_bytes.push_back(8'(count >> 8));
		list_bytes.push_back(8'(count));
		repeat (count * span) begin
			idx = 16'($urandom);
			list_bytes.push_back(idx[15:8]);
			list_bytes.push_back(idx[7:0]);
		end
	endtask

	// Stimulus: a directed opening, then phases that each set both registers and send lists.
	initial begin
		logic [2:0]  tc;
		logic [23:0] len;
		int          draw;
		arst_n = 1'b0;
		list_valid = 1'b0;
		list_item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TUPLE_COUNT;
		cfg_data = '0;
		hold_req = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// With the list length still zero, a command byte has no room for a header.
		send_byte(CMD_TRIS, 1'b1);
		settle();
		write_registers(3'd1, LEN_MAX);
		// One quad with extreme indices, an empty strip run, a zero byte and an ignored byte.
		list_bytes = {CMD_QUADS, 8'h00, 8'h04, 8'hff, 8'hff, 8'h00, 8'h00, 8'h12, 8'h34,
			8'hab, 8'hcd, CMD_STRIP, 8'h00, 8'h00, CMD_END, 8'h5a};
		send_list();
		list_bytes = {CMD_UNKNOWN};
		send_list();
		// A count just above the largest allowed run.
		list_bytes = {CMD_FAN | 8'h07, 8'((MAX_RUN + 1) >> 8), 8'(MAX_RUN + 1)};
		send_list();

		for (int p = 0; p < 8 || items_sent < ITEM_TARGET; p++) begin
			tc = (p < 8) ? TUPLE_SWEEP[p] : 3'($urandom_range(0, 7));
			if (p == 2)
				build_fan(FAN_LONG, tuple_span(tc));
			else
				build_list(tuple_span(tc));
			draw = $urandom_range(0, 9);
			if (p == 1 || p == 2 || draw == 8)
				len = LEN_MAX;
			else if (p == 3)
				len = '0;
			else if (draw < 6)
				len = 24'(list_bytes.size());
			else if (draw < 8)
				len = 24'($urandom_range(0, list_bytes.size() - 1));
			else
				len = 24'(list_bytes.size() + $urandom_range(1, 20));
			settle();
			write_registers(tc, len);
			// Ask the receiver for one long hold-off while the long fan keeps coming.
			if (p == 2)
				hold_req <= 1'b1;
			send_list();
			if (p == 2 || $urandom_range(0, 2) == 0) begin
				build_list(tuple_span(tc));
				send_list();
			end
		end

		settle();
		$display("Run covered %0d list bytes under %0d register settings, all four primitive kinds,",
			bytes_taken, settings_run);
		$display("truncated and terminated lists, and %0d corners checked.", corners_checked);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Corner receiver: random stall before each request, plus one long hold-off on demand.
	initial begin
		int gap;
		int taken;
		bit steady;
		bit held;
		tri_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (taken % 16 == 0)
				steady = ($urandom_range(0, 2) == 0);
			gap = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (hold_req && !held) begin
				gap = HOLD_CYCLES;
				held = 1'b1;
			end
			if (gap != 0) begin
				tri_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			tri_stall <= 1'b0;
			@(posedge clk);
			while (!tri_valid)
				@(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	// Watchdog: too many cycles without any request accepted ends the run.
	initial begin
		int idle;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((list_valid && !list_stall) || (tri_valid && !tri_stall)
					|| (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Watchdog: no request accepted for %0d cycles.", WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
